### rtl/core/sat_pkg.sv
// Shared types and constants for the segment address translator.
// No dependencies; imported by every module of the block but sat_ram.
package sat_pkg;

    // Default sizes, handed to the top level parameters
    localparam int DEF_TABLE_ENTRIES = 16;
    localparam int DEF_ADDRESS_BITS  = 32;

    // Segment size register
    localparam int              CFG_W         = 17;
    localparam logic [CFG_W-1:0] MAX_SEG_RESET = 17'd64;
    localparam logic [CFG_W-1:0] MAX_SEG_LIMIT = 17'd65536;

    // Command codes
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_WRITE  = 2'd1;
    localparam logic [1:0] CMD_XLATE  = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_SEGFAULT = 2'd1;
    localparam logic [1:0] ST_MISSING  = 2'd2;
    localparam logic [1:0] ST_UPDATED  = 2'd3;

    // Input word
    typedef struct packed {
        logic [1:0]  cmd;
        logic [3:0]  slot;
        logic [31:0] entry_id;
        logic [31:0] entry_base;
        logic [31:0] entry_size;
        logic [31:0] logical_address;
    } t_sat_in;

    // Result word
    typedef struct packed {
        logic [31:0] physical_address;
        logic [31:0] segment_number;
        logic [15:0] offset;
        logic [1:0]  status;
    } t_sat_out;

    // One table entry as stored in the RAM
    typedef struct packed {
        logic [31:0] id;
        logic [31:0] base;
        logic [31:0] size;
    } t_entry;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_SEARCH,
        S_DONE
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic tbl_clear;
        logic tbl_write;
        logic div_step;
        logic srch_step;
        logic res_upd;
        logic res_xlt;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic div_last;
        logic srch_hit;
        logic srch_miss;
    } t_dp_sts;

endpackage

### rtl/core/segment_address_translator.sv
// Top level of the segment address translator: controller plus datapath.
// Depends on sat_pkg, sat_ctrl, sat_dp (and sat_ram through sat_dp).
//
//  port group        dir  handshake           word
//  ----------------  ---  ------------------  --------------------------
//  command           in   start / busy        i_in  (t_sat_in)
//  result            out  o_valid (strobe)    o_out (t_sat_out)
//  segment size reg  in   i_cfg_we            i_cfg_data (17 bits)
//
//  A word is taken when start is high and busy is low; busy then stays high
//  until the result strobe. Clear, write and unused commands go straight to
//  the report state. A translate first runs the bit-serial divider, then
//  walks the table RAM one read per cycle until a valid slot matches or the
//  last slot is read, so it takes longer the higher the matching slot.
//  Reset is synchronous and active low; it sets the segment size to 64 and
//  empties the table. The result strobe is high for a single cycle; nothing
//  stalls it.
module segment_address_translator #(
    parameter int TABLE_ENTRIES = sat_pkg::DEF_TABLE_ENTRIES,
    parameter int ADDRESS_BITS  = sat_pkg::DEF_ADDRESS_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  sat_pkg::t_sat_in          i_in,
    output logic                      o_valid,
    output sat_pkg::t_sat_out         o_out,
    input  logic                      i_cfg_we,
    input  logic [sat_pkg::CFG_W-1:0] i_cfg_data
);
    import sat_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // sequencer
    sat_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cmd   (i_in.cmd),
        .i_sts   (dp_sts),
        .o_cmd   (dp_cmd),
        .o_busy  (busy),
        .o_done  (o_valid)
    );

    // datapath
    sat_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .ADDRESS_BITS  (ADDRESS_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_cmd      (dp_cmd),
        .o_sts      (dp_sts),
        .o_out      (o_out)
    );

endmodule

### rtl/core/sat_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [ADR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [ADR_W-1:0] i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/sat_ctrl.sv
// Sequencer for the segment address translator: accept, divide, search, report.
// Depends on sat_pkg.
module sat_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [1:0]      i_cmd,
    input  sat_pkg::t_dp_sts i_sts,
    output sat_pkg::t_dp_cmd o_cmd,
    output logic            o_busy,
    output logic            o_done
);
    import sat_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = (i_cmd == CMD_XLATE) ? S_DIV : S_DONE;
                end
            end
            S_DIV: begin
                if (i_sts.div_last) begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (i_sts.srch_hit || i_sts.srch_miss) begin
                    n_state = S_DONE;
                end
            end
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        o_done = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_busy          = 1'b0;
                o_cmd.load      = i_start;
                o_cmd.tbl_clear = i_start && (i_cmd == CMD_CLEAR);
                o_cmd.tbl_write = i_start && (i_cmd == CMD_WRITE);
                o_cmd.res_upd   = i_start && (i_cmd != CMD_XLATE);
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            S_SEARCH: begin
                o_cmd.srch_step = 1'b1;
                o_cmd.res_xlt   = i_sts.srch_hit || i_sts.srch_miss;
            end
            S_DONE: begin
                o_done = 1'b1;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

endmodule

### rtl/core/sat_dp.sv
// Datapath: segment size register, bit-serial divider, segment table and search.
// Depends on sat_pkg and sat_ram.
module sat_dp #(
    parameter int TABLE_ENTRIES = sat_pkg::DEF_TABLE_ENTRIES,
    parameter int ADDRESS_BITS  = sat_pkg::DEF_ADDRESS_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [sat_pkg::CFG_W-1:0] i_cfg_data,
    input  sat_pkg::t_sat_in          i_in,
    input  sat_pkg::t_dp_cmd          i_cmd,
    output sat_pkg::t_dp_sts          o_sts,
    output sat_pkg::t_sat_out         o_out
);
    import sat_pkg::*;

    localparam int          IDX_W     = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int          BIT_W     = $clog2(ADDRESS_BITS);
    localparam logic [31:0] ADDR_MASK = 32'((64'd1 << ADDRESS_BITS) - 64'd1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(ADDRESS_BITS - 1);

    logic [CFG_W-1:0]        r_max_seg;
    logic [CFG_W-1:0]        r_div;
    logic [CFG_W-1:0]        n_div;
    logic [ADDRESS_BITS-1:0] r_dvd;
    logic [CFG_W-1:0]        r_rem;
    logic [BIT_W-1:0]        r_bit;
    logic [CFG_W:0]          trial;
    logic [CFG_W:0]          diff;
    logic                    qbit;
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [IDX_W-1:0]        r_idx;
    logic [IDX_W-1:0]        r_pidx;
    logic                    r_pend;
    logic                    slot_ok;
    logic [IDX_W-1:0]        wr_idx;
    t_entry                  wr_entry;
    t_entry                  rd_entry;
    logic                    match;
    logic [31:0]             segno;
    logic [31:0]             off_ext;
    t_sat_out                r_out;

    // segment size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_seg <= MAX_SEG_RESET;
        end else if (i_cfg_we) begin
            r_max_seg <= i_cfg_data;
        end
    end

    // zero acts as one, anything above the limit as the limit
    always_comb begin
        if (r_max_seg == '0) begin
            n_div = CFG_W'(1);
        end else if (r_max_seg > MAX_SEG_LIMIT) begin
            n_div = MAX_SEG_LIMIT;
        end else begin
            n_div = r_max_seg;
        end
    end

    // restoring divider step, one quotient bit per cycle
    assign trial = {r_rem, r_dvd[ADDRESS_BITS-1]};
    assign diff  = trial - {1'b0, r_div};
    assign qbit  = (trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dvd <= i_in.logical_address[ADDRESS_BITS-1:0];
            r_rem <= '0;
            r_div <= n_div;
        end else if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[ADDRESS_BITS-2:0], qbit};
            r_rem <= qbit ? diff[CFG_W-1:0] : trial[CFG_W-1:0];
        end
    end

    // divider bit counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= '0;
        end else if (i_cmd.load) begin
            r_bit <= '0;
        end else if (i_cmd.div_step && (r_bit != LAST_BIT)) begin
            r_bit <= r_bit + BIT_W'(1);
        end
    end

    assign o_sts.div_last = (r_bit == LAST_BIT);

    // table write path
    assign slot_ok  = ({5'd0, i_in.slot} < 9'(TABLE_ENTRIES));
    assign wr_idx   = IDX_W'(i_in.slot);
    assign wr_entry = '{id: i_in.entry_id, base: i_in.entry_base, size: i_in.entry_size};

    // valid bits, cleared at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.tbl_clear) begin
            r_valid <= '0;
        end else if (i_cmd.tbl_write && slot_ok) begin
            r_valid[wr_idx] <= 1'b1;
        end
    end

    sat_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (i_cmd.tbl_write && slot_ok),
        .i_waddr (wr_idx),
        .i_wdata (wr_entry),
        .i_raddr (r_idx),
        .o_rdata (rd_entry)
    );

    // search walk: address issued now, entry compared next cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_pidx <= '0;
            r_pend <= 1'b0;
        end else if (i_cmd.load) begin
            r_idx  <= '0;
            r_pidx <= '0;
            r_pend <= 1'b0;
        end else if (i_cmd.srch_step) begin
            r_pend <= 1'b1;
            r_pidx <= r_idx;
            if (r_idx != LAST_IDX) begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

    assign segno   = 32'(r_dvd);
    assign off_ext = 32'(r_rem[15:0]);
    assign match   = r_pend && r_valid[r_pidx] && (rd_entry.id == segno);

    assign o_sts.srch_hit  = match;
    assign o_sts.srch_miss = r_pend && (r_pidx == LAST_IDX) && !match;

    // result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_upd) begin
            r_out <= '{physical_address: 32'd0, segment_number: 32'd0,
                       offset: 16'd0, status: ST_UPDATED};
        end else if (i_cmd.res_xlt) begin
            r_out.segment_number <= segno;
            r_out.offset         <= r_rem[15:0];
            if (!match) begin
                r_out.physical_address <= 32'd0;
                r_out.status           <= ST_MISSING;
            end else if (off_ext < rd_entry.size) begin
                r_out.physical_address <= (rd_entry.base + off_ext) & ADDR_MASK;
                r_out.status           <= ST_OK;
            end else begin
                r_out.physical_address <= 32'd0;
                r_out.status           <= ST_SEGFAULT;
            end
        end
    end

    assign o_out = r_out;

endmodule

### rtl/core/sat_checker.sv
// Port-level checks for the segment address translator, bound to the top level.
// Depends on sat_pkg and segment_address_translator.
module sat_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_valid,
    input sat_pkg::t_sat_out o_out
);
    import sat_pkg::*;

    // an accepted word makes the block busy on the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not raise busy");

    // a result only appears while a word is in flight
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result strobe while idle");

    // one result per word: the strobe never repeats back to back
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe repeated");

    // only a successful translation carries a physical address
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_out.status != ST_OK) |-> (o_out.physical_address == 32'd0))
        else $error("physical address set on a failed translation");

    // table updates report nothing else
    a_update_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_out.status == ST_UPDATED)
            |-> (o_out.segment_number == 32'd0) && (o_out.offset == 16'd0))
        else $error("table update result carries address fields");

endmodule

bind segment_address_translator sat_checker u_sat_checker (.*);

### verif/segment_address_translator_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for segment_address_translator: drives table, translate and
// unused commands and segment size writes, and checks every result word against a model or a directed expectation.
// Depends on sat_pkg and the RTL of the block; reads no files.
module segment_address_translator_tb;
    import sat_pkg::*;

    localparam int N_SLOTS    = DEF_TABLE_ENTRIES;
    localparam int N_PHASES   = 10;
    localparam int PHASE_WORDS = 170;

    // One row of the directed table; typed rows carry their expected word
    typedef struct packed {
        t_sat_in  word;
        logic     typed;
        t_sat_out want;
    } t_dir_row;

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    t_sat_in          i_in;
    logic             o_valid;
    t_sat_out         o_out;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_data;

    // Model copy of the segment table and the size register
    bit               seg_valid [N_SLOTS];
    logic [31:0]      seg_id    [N_SLOTS];
    logic [31:0]      seg_base  [N_SLOTS];
    logic [31:0]      seg_len   [N_SLOTS];
    logic [CFG_W-1:0] seg_size_reg;

    t_sat_out         pending_results [$];
    logic [31:0]      id_pool [6];
    int               fail_count;
    bit               burst_mode;

    // Segment size sequence; the first phase runs on the reset value
    logic [CFG_W-1:0] size_plan [N_PHASES] = '{
        MAX_SEG_RESET, 17'd1, MAX_SEG_LIMIT, 17'd0, 17'h1FFFF,
        17'd3, 17'd1000, 17'd65535, 17'd65537, MAX_SEG_RESET
    };

    segment_address_translator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_in       (i_in),
        .o_valid    (o_valid),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Zero reads as 1, anything above the limit as the limit
    function automatic logic [31:0] effective_divisor();
        if (seg_size_reg == '0)
            return 32'd1;
        if (seg_size_reg > MAX_SEG_LIMIT)
            return 32'(MAX_SEG_LIMIT);
        return 32'(seg_size_reg);
    endfunction

    // Applies one command word to the model table and returns its result word
    function automatic t_sat_out apply_command(t_sat_in w);
        t_sat_out    r;
        logic [31:0] d;
        logic [31:0] q;
        logic [31:0] m;
        int          hit;
        r = '0;
        r.status = ST_UPDATED;
        hit = -1;
        case (w.cmd)
            CMD_CLEAR: begin
                for (int i = 0; i < N_SLOTS; i++)
                    seg_valid[i] = 1'b0;
            end
            CMD_WRITE: begin
                seg_valid[w.slot] = 1'b1;
                seg_id[w.slot]    = w.entry_id;
                seg_base[w.slot]  = w.entry_base;
                seg_len[w.slot]   = w.entry_size;
            end
            CMD_XLATE: begin
                d = effective_divisor();
                q = w.logical_address / d;
                m = w.logical_address % d;
                r.segment_number = q;
                r.offset = m[15:0];
                // lowest matching slot wins
                for (int i = 0; i < N_SLOTS; i++)
                    if (hit < 0 && seg_valid[i] && seg_id[i] == q)
                        hit = i;
                if (hit < 0) begin
                    r.status = ST_MISSING;
                end else if (seg_len[hit] > m) begin
                    r.physical_address = seg_base[hit] + m;
                    r.status = ST_OK;
                end else begin
                    r.status = ST_SEGFAULT;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic t_sat_in cmd_word(logic [1:0] cmd, logic [3:0] slot, logic [31:0] id,
                                         logic [31:0] base, logic [31:0] len,
                                         logic [31:0] la);
        t_sat_in w;
        w.cmd = cmd;
        w.slot = slot;
        w.entry_id = id;
        w.entry_base = base;
        w.entry_size = len;
        w.logical_address = la;
        return w;
    endfunction

    function automatic t_sat_out res_word(logic [31:0] phys, logic [31:0] segno,
                                          logic [15:0] off, logic [1:0] st);
        t_sat_out r;
        r.physical_address = phys;
        r.segment_number = segno;
        r.offset = off;
        r.status = st;
        return r;
    endfunction

    // Random word: mostly table writes from the id pool and translates aimed at them
    function automatic t_sat_in random_word();
        t_sat_in     w;
        logic [31:0] d;
        logic [63:0] la;
        int          pick;
        d = effective_divisor();
        w = cmd_word(CMD_XLATE, 4'($urandom), $urandom, $urandom, $urandom, $urandom);
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            w.cmd = CMD_CLEAR;
        end else if (pick < 6) begin
            w.cmd = CMD_UNUSED;
        end else if (pick < 36) begin
            w.cmd = CMD_WRITE;
            if ($urandom_range(0, 6) != 0)
                w.entry_id = id_pool[$urandom_range(0, 5)];
            case ($urandom_range(0, 9))
                0: w.entry_size = '0;
                1, 2: ;
                default: w.entry_size = $urandom_range(0, d + 1);
            endcase
            // base near the top so base plus offset wraps
            if ($urandom_range(0, 9) == 0)
                w.entry_base = 32'hFFFF_FFFF - $urandom_range(0, d);
        end else if (pick < 85) begin
            la = {32'b0, id_pool[$urandom_range(0, 5)]} * {32'b0, d}
                 + 64'($urandom_range(0, d - 1));
            if (la > 64'hFFFF_FFFF)
                la = 64'hFFFF_FFFF;
            w.logical_address = la[31:0];
        end else if (pick < 90) begin
            w.logical_address = $urandom_range(0, 1) ? '1 : '0;
        end
        return w;
    endfunction

    task automatic check_result(t_sat_out want, t_sat_out got);
        if (got.physical_address !== want.physical_address) begin
            $display("%0t: physical_address expected %h got %h",
                     $time, want.physical_address, got.physical_address);
            fail_count++;
        end
        if (got.segment_number !== want.segment_number) begin
            $display("%0t: segment_number expected %h got %h",
                     $time, want.segment_number, got.segment_number);
            fail_count++;
        end
        if (got.offset !== want.offset) begin
            $display("%0t: offset expected %h got %h", $time, want.offset, got.offset);
            fail_count++;
        end
        if (got.status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
            fail_count++;
        end
    endtask

    // Presents one word after a random gap (none in burst mode) and waits until it is taken
    task automatic send_word(t_sat_in w, logic typed, t_sat_out want);
        t_sat_out pred;
        int       gap;
        gap = burst_mode ? 0 : $urandom_range(0, 17);
        if ($urandom_range(0, 39) == 0)
            burst_mode = !burst_mode;
        @(negedge i_clk);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in = w;
        start = 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        pred = apply_command(w);
        pending_results.push_back(typed ? want : pred);
    endtask

    // Stops sending and waits for every outstanding result
    task automatic drain();
        @(negedge i_clk);
        start = 1'b0;
        while (pending_results.size() != 0 || busy !== 1'b0)
            @(posedge i_clk);
    endtask

    task automatic write_seg_size(logic [CFG_W-1:0] v);
        drain();
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_data = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        seg_size_reg = v;
    endtask

    // Result monitor: every strobe must match the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result word %h with nothing expected", $time, o_out);
                fail_count++;
            end else begin
                check_result(pending_results.pop_front(), o_out);
            end
        end
    end

    initial begin
        t_dir_row    rows [$];
        logic [31:0] d;
        logic [31:0] max_id;
        start = 1'b0;
        i_in = '0;
        i_cfg_we = 1'b0;
        i_cfg_data = MAX_SEG_RESET;
        i_rst_n = 1'b0;
        fail_count = 0;
        burst_mode = 1'b0;
        seg_size_reg = MAX_SEG_RESET;
        for (int i = 0; i < N_SLOTS; i++)
            seg_valid[i] = 1'b0;

        // Directed table at the reset segment size of 64
        rows.push_back('{cmd_word(CMD_XLATE, 0, 0, 0, 0, 32'h0), 1'b1,
                         res_word(0, 0, 0, ST_MISSING)});
        rows.push_back('{cmd_word(CMD_XLATE, 0, 0, 0, 0, 32'hFFFF_FFFF), 1'b1,
                         res_word(0, 32'h03FF_FFFF, 16'd63, ST_MISSING)});
        rows.push_back('{cmd_word(CMD_UNUSED, 4'hF, '1, '1, '1, '1), 1'b1,
                         res_word(0, 0, 0, ST_UPDATED)});
        rows.push_back('{cmd_word(CMD_WRITE, 0, 0, 32'h1000, 32'd64, 0), 1'b1,
                         res_word(0, 0, 0, ST_UPDATED)});
        rows.push_back('{cmd_word(CMD_XLATE, 0, 0, 0, 0, 32'h3F), 1'b0, '0});
        rows.push_back('{cmd_word(CMD_XLATE, 0, 0, 0, 0, 32'h40), 1'b0, '0});
        rows.push_back('{cmd_word(CMD_WRITE, 4'hF, 32'h03FF_FFFF, 32'hFFFF_FFF0, '1, 0), 1'b1,
                         res_word(0, 0, 0, ST_UPDATED)});
        rows.push_back('{cmd_word(CMD_XLATE, 0, 0, 0, 0, 32'hFFFF_FFFF), 1'b0, '0});
        // zero-length segment, then a lower slot with the same id
        rows.push_back('{cmd_word(CMD_WRITE, 4'd3, 32'd5, 32'h2000, 32'd0, 0), 1'b1,
                         res_word(0, 0, 0, ST_UPDATED)});
        rows.push_back('{cmd_word(CMD_XLATE, 0, 0, 0, 0, 32'h140), 1'b0, '0});
        rows.push_back('{cmd_word(CMD_WRITE, 4'd1, 32'd5, 32'h3000, 32'd10, 0), 1'b1,
                         res_word(0, 0, 0, ST_UPDATED)});
        rows.push_back('{cmd_word(CMD_XLATE, 0, 0, 0, 0, 32'h149), 1'b0, '0});
        rows.push_back('{cmd_word(CMD_XLATE, 0, 0, 0, 0, 32'h14A), 1'b0, '0});
        rows.push_back('{cmd_word(CMD_WRITE, 4'd2, '1, '1, '1, 0), 1'b1,
                         res_word(0, 0, 0, ST_UPDATED)});
        rows.push_back('{cmd_word(CMD_XLATE, 0, 0, 0, 0, 32'h7FFF_FFC0), 1'b0, '0});
        rows.push_back('{cmd_word(CMD_CLEAR, 4'hF, '1, '1, '1, '1), 1'b1,
                         res_word(0, 0, 0, ST_UPDATED)});
        rows.push_back('{cmd_word(CMD_XLATE, 0, 0, 0, 0, 32'h3F), 1'b0, '0});
        rows.push_back('{cmd_word(CMD_WRITE, 4'd7, 32'd1, 32'h0, 32'd1, 0), 1'b1,
                         res_word(0, 0, 0, ST_UPDATED)});
        rows.push_back('{cmd_word(CMD_XLATE, 0, 0, 0, 0, 32'h40), 1'b0, '0});
        rows.push_back('{cmd_word(CMD_XLATE, 0, 0, 0, 0, 32'h41), 1'b0, '0});
        rows.push_back('{cmd_word(CMD_XLATE, 0, 0, 0, 0, 32'h0), 1'b0, '0});

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (rows[k])
            send_word(rows[k].word, rows[k].typed, rows[k].want);

        // Random phases, one segment size each
        for (int p = 0; p < N_PHASES; p++) begin
            if (p > 0)
                write_seg_size(size_plan[p]);
            d = effective_divisor();
            max_id = 32'hFFFF_FFFF / d;
            id_pool[0] = '0;
            id_pool[1] = max_id;
            for (int k = 2; k < 6; k++)
                id_pool[k] = 32'({32'b0, $urandom} % ({32'b0, max_id} + 64'd1));
            repeat (PHASE_WORDS)
                send_word(random_word(), 1'b0, '0);
        end

        drain();
        repeat (60) @(posedge i_clk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Run limit
    initial begin
        #8000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

### files.f
rtl/core/sat_pkg.sv
rtl/core/sat_ram.sv
rtl/core/sat_ctrl.sv
rtl/core/sat_dp.sv
rtl/core/segment_address_translator.sv
rtl/core/sat_checker.sv
verif/segment_address_translator_tb.sv
